// ===== hdl/ktl_pkg.sv =====
// ----------------------------------------------------------------------------
// ktl_pkg
// Shared types and codes for the keyed table: operation and status codes,
// the controller state and the command bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package ktl_pkg;

   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_MISSING   = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // broadcast to all cells each cycle
   typedef struct packed {
      logic                      cmp_en;    // latch key match flag
      logic signed [KEY_W-1:0]   cmp_key;
      logic                      ins_en;    // append at slot == count
      logic                      del_en;    // compact: flagged cells pull from neighbor
      logic signed [KEY_W-1:0]   wr_key;
      logic signed [VALUE_W-1:0] wr_value;
   } cell_cmd_type;

endpackage

// ===== hdl/ktl_cell.sv =====
// ----------------------------------------------------------------------------
// ktl_cell
// One table slot: holds a key and a value, flags a key match, takes a new
// entry on insert and pulls its upper neighbor's entry on a remove.
// ----------------------------------------------------------------------------
module ktl_cell
   import ktl_pkg::*;
#(
   parameter int CAPACITY = 128,
   parameter int INDEX    = 0
) (
   input  logic                             clock,
   input  cell_cmd_type                     cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]    count,
   input  logic                             shift_en,
   input  logic signed [KEY_W-1:0]          up_key,
   input  logic signed [VALUE_W-1:0]        up_value,
   output logic signed [KEY_W-1:0]          key_out,
   output logic signed [VALUE_W-1:0]        value_out,
   output logic                             match
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic signed [KEY_W-1:0]   key_ff,   key_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      match_ff, match_in;
   logic                      live;

   // slot holds an entry when its index is below the fill count
   assign live = CNT_W'(INDEX) < count;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (cmd.cmp_en) begin
         match_in = live && (key_ff == cmd.cmp_key);
      end
      if (cmd.ins_en && (count == CNT_W'(INDEX))) begin
         key_in   = cmd.wr_key;
         value_in = cmd.wr_value;
      end else if (cmd.del_en && shift_en) begin
         key_in   = up_key;
         value_in = up_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign match     = match_ff;

endmodule

// ===== hdl/keyed_table_insert_delete_lookup.sv =====
// ----------------------------------------------------------------------------
// keyed_table_insert_delete_lookup
// Packed, unsorted key/value table with insert, remove and search, built as
// a row of cells that compare in parallel and compact by neighbor shift.
// ----------------------------------------------------------------------------
// A transaction runs as a compare step and then an execute step: on the
// accepting edge every cell compares its key with the request key and
// latches a match flag; in the execute state the controller applies the
// insert (write at slot = count) or the remove (every cell at or above the
// match pulls its upper neighbor), and loads the response register. A new
// request is taken only once the controller is back in idle, so requests
// never overlap. If the previous response has not been taken, the execute
// step waits until the response register frees up. No clearing pass after
// reset: only slots below the fill count are ever looked at.
module keyed_table_insert_delete_lookup
   import ktl_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] item_key, [63:32] item_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [2:0] status, [34:3] found_value,
                                    // [42:35] entry_total, [47:43] zero
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   // controller state
   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // held request
   op_type                    op_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic signed [VALUE_W-1:0] value_ff;

   // response payload
   status_type                status_ff;
   logic signed [VALUE_W-1:0] found_ff;
   logic [TOTAL_W-1:0]        total_ff;

   logic req_accept;
   logic exec_active;
   logic commit;

   // cell row wiring
   cell_cmd_type              cmd;
   logic [CAPACITY-1:0]       match_vec;
   logic [CAPACITY-1:0]       shift_vec;
   logic signed [KEY_W-1:0]   cell_key   [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];

   // execute decision
   status_type                status_sel;
   logic signed [VALUE_W-1:0] found_sel;
   logic signed [VALUE_W-1:0] hit_value;
   logic                      hit;
   logic                      is_full;
   logic                      is_empty;
   logic                      ins_ok;
   logic                      del_ok;

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      exec_active = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready  = 1'b1;
         ST_EXEC: exec_active = 1'b1;
         default: begin
            req_tready  = 1'b0;
            exec_active = 1'b0;
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;
   // apply the operation only when the response register can take the result
   assign commit     = exec_active && (!rsp_valid_ff || rsp_tready);

   // ---------------- match reduction ----------------
   // keys are unique, so at most one flag is set; an OR tree picks the value
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_value = hit_value | (match_vec[i] ? cell_value[i] : '0);
      end
   end

   // prefix OR: cells at and above the match compact on a remove
   always_comb begin
      shift_vec = match_vec;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         shift_vec = shift_vec | (shift_vec << s);
      end
   end

   assign hit      = |match_vec;
   assign is_full  = count_ff == CNT_W'(CAPACITY);
   assign is_empty = count_ff == '0;

   always_comb begin
      status_sel = STATUS_OK;
      found_sel  = '0;
      ins_ok     = 1'b0;
      del_ok     = 1'b0;
      count_in   = count_ff;
      case (op_ff)
         OP_INSERT: begin
            if (is_full) begin
               status_sel = STATUS_FULL;
            end else if (hit) begin
               status_sel = STATUS_DUPLICATE;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               status_sel = STATUS_EMPTY;
            end else if (!hit) begin
               status_sel = STATUS_MISSING;
            end else begin
               del_ok   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         OP_SEARCH: begin
            if (is_empty) begin
               status_sel = STATUS_EMPTY;
            end else if (!hit) begin
               status_sel = STATUS_MISSING;
            end else begin
               found_sel = hit_value;
            end
         end
         default: begin
            // undefined selector: no effect, zero result
            status_sel = STATUS_OK;
         end
      endcase
   end

   // ---------------- cell row ----------------
   always_comb begin
      cmd.cmp_en   = req_accept;
      cmd.cmp_key  = req_tdata[31:0];
      cmd.ins_en   = commit && ins_ok;
      cmd.del_en   = commit && del_ok;
      cmd.wr_key   = key_ff;
      cmd.wr_value = value_ff;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_W-1:0]   up_key;
      logic signed [VALUE_W-1:0] up_value;

      if (g == CAPACITY - 1) begin : g_top
         // nothing above the last slot; it keeps its own (now unused) entry
         assign up_key   = cell_key[g];
         assign up_value = cell_value[g];
      end else begin : g_mid
         assign up_key   = cell_key[g+1];
         assign up_value = cell_value[g+1];
      end

      ktl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (g)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .shift_en  (shift_vec[g]),
         .up_key    (up_key),
         .up_value  (up_value),
         .key_out   (cell_key[g]),
         .value_out (cell_value[g]),
         .match     (match_vec[g])
      );
   end

   // ---------------- registers ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (commit)     rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= op_type'(req_tuser);
         key_ff   <= req_tdata[31:0];
         value_ff <= req_tdata[63:32];
      end
      if (commit) begin
         status_ff <= status_sel;
         found_ff  <= found_sel;
         total_ff  <= TOTAL_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, total_ff, found_ff, status_ff};

   // ---------------- assertions ----------------
   // fill count never runs past the table size
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // unique keys: at most one cell may flag a match
   a_unique_match : assert property (@(posedge clock) disable iff (reset)
      exec_active |-> $onehot0(match_vec))
      else $error("more than one cell matched the key");

   // a successful insert grows the table by exactly one entry
   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (commit && ins_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not advance the fill count");

   // a returned value only comes with an ok status
   a_found_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (found_ff != '0)) |-> (status_ff == STATUS_OK))
      else $error("value returned with an error status");

endmodule

// ===== tb/tb_keyed_table_insert_delete_lookup.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_table_insert_delete_lookup
// Self-checking bench for the keyed table. Requests go in on the req_ stream
// with bursty valid. Responses come out on the rsp_ stream under a changing
// ready pattern. A scoreboard object keeps its own copy of the table and
// predicts each response. Each response is then checked field by field.
// ----------------------------------------------------------------------------
module tb_keyed_table_insert_delete_lookup
   import ktl_pkg::*;
();

   localparam int TABLE_DEPTH = 128;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 10;

   // receiver ready patterns
   localparam int RDY_ALWAYS = 0;
   localparam int RDY_COIN   = 1;
   localparam int RDY_SPARSE = 2;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] item_key, [63:32] item_value
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [2:0] status, [34:3] found_value,
                                   // [42:35] entry_total, [47:43] zero

   typedef struct {
      status_type         status;
      logic signed [31:0] found;
      logic [7:0]         total;
   } table_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow copy of the table plus a queue of predicted responses
   // -------------------------------------------------------------------------
   class table_scoreboard;
      logic signed [31:0] key_tab [TABLE_DEPTH];
      logic signed [31:0] value_tab [TABLE_DEPTH];
      int                 entry_count;
      table_result_type   expected_q [$];
      int                 errors;

      function new();
         entry_count = 0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic signed [31:0] key_at(int idx);
         return key_tab[idx];
      endfunction

      // Update the shadow table for one accepted request and queue the
      // response it should produce.
      function void note_request(op_type op, logic signed [31:0] key,
                                 logic signed [31:0] value);
         table_result_type res;
         int               pos;
         int               i;
         res.status = STATUS_OK;
         res.found  = '0;
         // first match only; duplicates never get in
         pos = entry_count;
         for (i = 0; i < entry_count; i++) begin
            if (key_tab[i] == key) begin
               pos = i;
               break;
            end
         end
         case (op)
            OP_INSERT: begin
               // fullness wins over the duplicate check
               if (entry_count >= TABLE_DEPTH) begin
                  res.status = STATUS_FULL;
               end else if (pos < entry_count) begin
                  res.status = STATUS_DUPLICATE;
               end else begin
                  key_tab[entry_count]   = key;
                  value_tab[entry_count] = value;
                  entry_count++;
               end
            end
            OP_REMOVE: begin
               if (entry_count == 0) begin
                  res.status = STATUS_EMPTY;
               end else if (pos >= entry_count) begin
                  res.status = STATUS_MISSING;
               end else begin
                  // close the gap, keeps insertion order
                  for (i = pos; i + 1 < entry_count; i++) begin
                     key_tab[i]   = key_tab[i + 1];
                     value_tab[i] = value_tab[i + 1];
                  end
                  entry_count--;
               end
            end
            OP_SEARCH: begin
               if (entry_count == 0) begin
                  res.status = STATUS_EMPTY;
               end else if (pos >= entry_count) begin
                  res.status = STATUS_MISSING;
               end else begin
                  res.found = value_tab[pos];
               end
            end
            default: ;   // unused selector: no change, zero response
         endcase
         res.total = entry_count[7:0];
         expected_q.push_back(res);
      endfunction

      function void check_response(logic [47:0] word);
         table_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: %h", word);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (word[2:0] !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, word[2:0]);
            errors++;
         end
         if (word[34:3] !== exp_res.found) begin
            $error("found_value: expected %h, actual %h", exp_res.found, word[34:3]);
            errors++;
         end
         if (word[42:35] !== exp_res.total) begin
            $error("entry_total: expected %0d, actual %0d", exp_res.total, word[42:35]);
            errors++;
         end
         if (word[47:43] !== 5'd0) begin
            $error("pad: expected 0, actual %h", word[47:43]);
            errors++;
         end
      endfunction
   endclass

   table_scoreboard table_sb;
   int              burst_left = 0;
   int              rdy_mode   = RDY_ALWAYS;
   int              rdy_left   = 0;
   int              cycle_count;

   keyed_table_insert_delete_lookup #(
      .CAPACITY (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit: a stuck handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: switches between always ready, coin flip and sparse ready
   // for stretches of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rdy_left   <= 0;
      end else begin
         if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(RDY_ALWAYS, RDY_SPARSE);
            rdy_left <= $urandom_range(20, 200);
         end else begin
            rdy_left <= rdy_left - 1;
         end
         case (rdy_mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_COIN:   rsp_tready <= $urandom_range(0, 1);
            default:    rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Response monitor: every completed rsp transaction is checked.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         table_sb.check_response(rsp_tdata);
      end
   end

   // Drive one request transaction. Bursts of random length are separated
   // by random gaps; a zero gap runs straight into the next burst.
   task automatic issue(op_type op, logic [31:0] key, logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 64)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_sb.note_request(op, key, value);
   endtask

   // Hold off the sender until every outstanding response is back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (table_sb.pending() != 0);
   endtask

   // Key either taken from the live table (hit) or fully random (miss).
   function automatic logic [31:0] pick_key(int hit_pct);
      if (table_sb.entry_count > 0 && $urandom_range(0, 99) < hit_pct)
         return table_sb.key_at($urandom_range(0, table_sb.entry_count - 1));
      return $urandom;
   endfunction

   // Weighted random mix; the remainder after insert and remove is mostly
   // search with a few unused selectors.
   task automatic run_mix(int n, int ins_pct, int rem_pct, int hit_pct);
      int     roll;
      op_type op;
      repeat (n) begin
         roll = $urandom_range(0, 99);
         if (roll < ins_pct)                op = OP_INSERT;
         else if (roll < ins_pct + rem_pct) op = OP_REMOVE;
         else if (roll < 97)                op = OP_SEARCH;
         else                               op = OP_NONE;
         issue(op, pick_key(op == OP_INSERT ? hit_pct / 4 : hit_pct), $urandom);
      end
   endtask

   initial begin
      table_sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // empty table, then the unused selector
      issue(OP_SEARCH, 32'h0000_0000, 32'h0);
      issue(OP_REMOVE, 32'h0000_0000, 32'h0);
      issue(OP_NONE,   32'h0000_0000, 32'h0);
      // extreme keys and values
      issue(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      issue(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      issue(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      issue(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // duplicate insert leaves the table alone
      issue(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
      issue(OP_SEARCH, 32'h7FFF_FFFF, 32'h0);
      issue(OP_SEARCH, 32'h0000_0000, 32'h0);
      issue(OP_SEARCH, 32'h8000_0000, 32'h0);
      // missing key
      issue(OP_SEARCH, 32'h1234_5678, 32'h0);
      issue(OP_REMOVE, 32'h1234_5678, 32'h0);
      // remove from the middle, then check the shifted entry
      issue(OP_REMOVE, 32'h7FFF_FFFF, 32'h0);
      issue(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
      // last, then first
      issue(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      issue(OP_REMOVE, 32'h8000_0000, 32'h0);
      issue(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_SEARCH, 32'h0000_0000, 32'h0);
      // table back to empty
      issue(OP_REMOVE, 32'h0000_0000, 32'h0);
      issue(OP_SEARCH, 32'h0000_0000, 32'h0);
      issue(OP_INSERT, 32'h0000_0005, 32'h0001_8000);
      issue(OP_SEARCH, 32'h0000_0005, 32'h0);
      wait_drained();

      // ---- random ----
      // fill well past capacity so full-table inserts show up
      run_mix(350, 70, 10, 40);
      wait_drained();
      // drain to empty so empty-table statuses show up
      run_mix(350, 10, 70, 85);
      wait_drained();
      // balanced churn around the middle
      run_mix(300, 35, 35, 60);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (table_sb.errors == 0 && table_sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
